// ----- rtl/vdn_pkg.sv -----
// Shared definitions for the vector direction normalize unit.
// Holds the fixed output format and the queue control struct; no dependencies.
package vdn_pkg;

	localparam int OUT_W       = 16;
	localparam int OUT_POS_MAX = 32767;
	localparam int OUT_NEG_MAX = 32768;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic valid;
		logic take;
	} vdn_link_t;

endpackage

// ----- rtl/vdn_front.sv -----
// Front end: forms per-axis differences, magnitudes and signs, and flags coincident points.
// Depends on vdn_pkg.
module vdn_front import vdn_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int ENTRY_W    = 3 * (COORD_BITS + 1) + 4
) (
	input  logic [COORD_BITS-1:0] from_x,
	input  logic [COORD_BITS-1:0] from_y,
	input  logic [COORD_BITS-1:0] from_z,
	input  logic [COORD_BITS-1:0] to_x,
	input  logic [COORD_BITS-1:0] to_y,
	input  logic [COORD_BITS-1:0] to_z,
	output logic [ENTRY_W-1:0]    entry
);

	localparam int M = COORD_BITS + 1;

	logic [2:0][COORD_BITS-1:0] fr;
	logic [2:0][COORD_BITS-1:0] tt;
	logic [2:0][M-1:0]          diff;
	logic [2:0][M-1:0]          mag;
	logic [2:0]                 sgn;
	logic                       zero;

	assign fr = {from_z, from_y, from_x};
	assign tt = {to_z, to_y, to_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {tt[i][COORD_BITS-1], tt[i]} - {fr[i][COORD_BITS-1], fr[i]};
			sgn[i]  = diff[i][M-1];
			mag[i]  = sgn[i] ? (~diff[i] + M'(1)) : diff[i];
		end
		zero = (diff == '0);
	end

	// Layout: zero flag, three signs, then three magnitudes.
	assign entry = {zero, sgn, mag};

endmodule

// ----- rtl/vdn_queue.sv -----
// Short queue between the front and back parts.
// Depends on vdn_pkg for its depth and link struct.
module vdn_queue import vdn_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	output vdn_link_t    link,
	input  logic         rd,
	output logic [W-1:0] rdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem [QUEUE_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full       = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign link.valid = (cnt_q != '0);
	assign link.take  = do_rd;
	assign do_wr      = wr && !full;
	assign do_rd      = rd && link.valid;
	assign rdata      = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

endmodule

// ----- rtl/vdn_back.sv -----
// Back end: squares, sum, bit-per-stage square root, bit-per-stage division, rounding.
// Depends on vdn_pkg for the output format.
module vdn_back import vdn_pkg::*; #(
	parameter int COORD_BITS    = 24,
	parameter int OUT_FRAC_BITS = 14,
	parameter int ENTRY_W       = 3 * (COORD_BITS + 1) + 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vdn_link_t               link,
	input  logic [ENTRY_W-1:0]      entry,
	output logic                    take,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] dir_x,
	output logic signed [OUT_W-1:0] dir_y,
	output logic signed [OUT_W-1:0] dir_z,
	output logic                    zero_length
);

	localparam int M  = COORD_BITS + 1;
	localparam int R  = COORD_BITS + 1;
	localparam int RW = R + 3;
	localparam int F  = OUT_FRAC_BITS;
	localparam int NP = R + F + 4;

	logic ce;

	logic [2:0][M-1:0] mag_p [NP];
	logic [2:0]        sgn_p [NP];
	logic              zero_p [NP];
	logic              vld_p [NP];

	logic [2:0][2*R-1:0] sq_s1;
	logic [2*R-1:0]      rad_s [R+1];
	logic [RW-1:0]       rem_s [R+1];
	logic [R-1:0]        root_s [R+1];
	logic [R-1:0]        len_s [F+2];
	logic [2:0][R:0]     dr_s [F+2];
	logic [2:0][F:0]     dq_s [F+2];
	logic [2:0][OUT_W-1:0] dir_s;

	// The whole back pipeline advances together whenever the output slot frees up.
	assign ce    = !vld_p[NP-1] || pop;
	assign take  = ce && link.valid;
	assign empty = !vld_p[NP-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NP; p++) begin
				vld_p[p] <= 1'b0;
			end
		end else if (ce) begin
			vld_p[0] <= link.valid;
			for (int p = 1; p < NP; p++) begin
				vld_p[p] <= vld_p[p-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mag_p[0]  <= entry[3*M-1:0];
			sgn_p[0]  <= entry[ENTRY_W-2:ENTRY_W-4];
			zero_p[0] <= entry[ENTRY_W-1];
			for (int p = 1; p < NP; p++) begin
				mag_p[p]  <= mag_p[p-1];
				sgn_p[p]  <= sgn_p[p-1];
				zero_p[p] <= zero_p[p-1];
			end
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= (2*R)'(entry[i*M +: M]) * (2*R)'(entry[i*M +: M]);
			end
			rad_s[0]  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	// Square root: two radicand bits per stage, one root bit per stage.
	for (genvar k = 1; k <= R; k++) begin : g_sqrt
		logic [RW-1:0] remsh;
		logic [RW-1:0] trial;
		logic          ge;
		assign remsh = {rem_s[k-1][RW-3:0], rad_s[k-1][2*R-1 -: 2]};
		assign trial = RW'({root_s[k-1], 2'b01});
		assign ge    = (remsh >= trial);
		always_ff @(posedge clk) begin
			if (ce) begin
				rad_s[k]  <= rad_s[k-1] << 2;
				rem_s[k]  <= ge ? (remsh - trial) : remsh;
				root_s[k] <= {root_s[k-1][R-2:0], ge};
			end
		end
	end

	assign len_s[0] = root_s[R];
	assign dr_s[0]  = '0;
	assign dq_s[0]  = '0;

	// Division: the first stage compares the magnitude itself, each later stage one
	// more fraction bit, so the quotient has OUT_FRAC_BITS+1 bits.
	for (genvar j = 1; j <= F + 1; j++) begin : g_div
		for (genvar c = 0; c < 3; c++) begin : g_comp
			logic [R:0] rin;
			logic       ge;
			if (j == 1) begin : g_first
				assign rin = {1'b0, mag_p[R+1][c]};
			end else begin : g_next
				assign rin = {dr_s[j-1][c][R-1:0], 1'b0};
			end
			assign ge = (rin >= {1'b0, len_s[j-1]});
			always_ff @(posedge clk) begin
				if (ce) begin
					dr_s[j][c] <= ge ? (rin - {1'b0, len_s[j-1]}) : rin;
					dq_s[j][c] <= {dq_s[j-1][c][F-1:0], ge};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				len_s[j] <= len_s[j-1];
			end
		end
	end

	// Rounding with ties away from zero, saturation, sign and the coincident-point case.
	for (genvar c = 0; c < 3; c++) begin : g_round
		logic          rnd;
		logic [F+1:0]  qr;
		logic [31:0]   qe;
		logic [31:0]   qs;
		assign rnd = ({dr_s[F+1][c], 1'b0} >= (R+2)'(len_s[F+1]));
		assign qr  = {1'b0, dq_s[F+1][c]} + (F+2)'(rnd);
		assign qe  = 32'(qr);
		always_comb begin
			if (sgn_p[NP-2][c]) begin
				qs = (qe > 32'(OUT_NEG_MAX)) ? 32'(OUT_NEG_MAX) : qe;
				qs = ~qs + 32'd1;
			end else begin
				qs = (qe > 32'(OUT_POS_MAX)) ? 32'(OUT_POS_MAX) : qe;
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				dir_s[c] <= zero_p[NP-2] ? '0 : qs[OUT_W-1:0];
			end
		end
	end

	assign dir_x       = dir_s[0];
	assign dir_y       = dir_s[1];
	assign dir_z       = dir_s[2];
	assign zero_length = zero_p[NP-1];

endmodule

// ----- rtl/vector3_direction_normalize_unit.sv -----
// Top level of the vector direction normalize unit.
// Depends on vdn_pkg, vdn_front, vdn_queue and vdn_back.
//
//  Channel   Handshake         Transfer when          Fields
//  input     push / full       push && !full          from_x/y/z, to_x/y/z
//  result    empty / pop       pop && !empty          dir_x/y/z, zero_length
//
// One vector can be transferred in every cycle while full is low, and one result
// leaves every cycle while each is popped when shown. An input goes from the queue into
// the square stage, then the sum, COORD_BITS+1 square root stages, OUT_FRAC_BITS+1
// divider stages and the rounding output register before its result is visible.
// Reset clears the queue and all stage valid bits; the result side then shows empty.
// A result not popped stalls the whole back pipeline; the four-entry queue keeps
// taking input until it fills, so full never depends on pop in the same cycle.
module vector3_direction_normalize_unit import vdn_pkg::*; #(
	parameter int COORD_BITS    = 24,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [COORD_BITS-1:0]   from_x,
	input  logic [COORD_BITS-1:0]   from_y,
	input  logic [COORD_BITS-1:0]   from_z,
	input  logic [COORD_BITS-1:0]   to_x,
	input  logic [COORD_BITS-1:0]   to_y,
	input  logic [COORD_BITS-1:0]   to_z,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] dir_x,
	output logic signed [OUT_W-1:0] dir_y,
	output logic signed [OUT_W-1:0] dir_z,
	output logic                    zero_length
);

	localparam int ENTRY_W = 3 * (COORD_BITS + 1) + 4;

	logic [ENTRY_W-1:0] front_entry;
	logic [ENTRY_W-1:0] head_entry;
	vdn_link_t          link;
	logic               take;

	// The front part classifies each vector as it is transferred in.
	vdn_front #(.COORD_BITS(COORD_BITS), .ENTRY_W(ENTRY_W)) u_front (
		.from_x(from_x), .from_y(from_y), .from_z(from_z),
		.to_x(to_x), .to_y(to_y), .to_z(to_z),
		.entry(front_entry)
	);

	// The queue lets the front keep accepting while the back is stalled.
	vdn_queue #(.W(ENTRY_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata(front_entry), .full(full),
		.link(link), .rd(take), .rdata(head_entry)
	);

	// The back part computes the length and the scaled components.
	vdn_back #(
		.COORD_BITS(COORD_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS), .ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.link(link), .entry(head_entry), .take(take),
		.empty(empty), .pop(pop),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.zero_length(zero_length)
	);

endmodule

// ----- rtl/vdn_checker.sv -----
// Port-level checker for the vector direction normalize unit and its bind.
// Depends on vdn_pkg for the output width.
module vdn_checker import vdn_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic                    empty,
	input logic                    pop,
	input logic signed [OUT_W-1:0] dir_x,
	input logic signed [OUT_W-1:0] dir_y,
	input logic signed [OUT_W-1:0] dir_z,
	input logic                    zero_length
);

	logic [7:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(push && !full) - 8'(pop && !empty);
		end
	end

	// A coincident pair always yields a zero vector.
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && zero_length) |-> (dir_x == '0 && dir_y == '0 && dir_z == '0))
		else $error("zero_length result with nonzero direction");

	// A result never appears without an input transfer still owed one.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != '0))
		else $error("result shown with no pending input");

	// A waiting result holds until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(dir_x) && $stable(dir_y)
			&& $stable(dir_z) && $stable(zero_length)))
		else $error("waiting result changed before transfer");

endmodule

bind vector3_direction_normalize_unit vdn_checker u_vdn_checker (.*);
